[src/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg: shared types, constants and microcode for the point stack table
// sizes, op and status codes, control word layout and the step program
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int DEPTH       = 64;
    localparam int COORD_WIDTH = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RADIUS_W    = 15;
    localparam int COUNT_W     = 7;
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int RR_W        = 2 * RADIUS_W;
    localparam int CMP_W       = (SQ_W + 1 > RR_W) ? SQ_W + 1 : RR_W;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_RADIUS = 3'd3,
        OP_MEMBER = 3'd4,
        OP_SIZE   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH_WR,
        S_POP,
        S_POP_DEC,
        S_REM,
        S_REM_INIT,
        S_REM_SCAN,
        S_REM_CHK,
        S_REM_SHINIT,
        S_REM_SHIFT,
        S_REM_DEC,
        S_RAD_INIT,
        S_RAD_SCAN,
        S_RAD_DONE,
        S_MEM_INIT,
        S_MEM_SCAN,
        S_MEM_DONE,
        S_SIZE,
        S_NOP,
        S_R_FULL,
        S_R_EMPTY,
        S_R_NOMATCH
    } step_t;

    // jump conditions: for the flag tests, true goes to target, false to nxt
    typedef enum logic [2:0] {
        JC_NONE,
        JC_DISPATCH,
        JC_FULL,
        JC_EMPTY,
        JC_HIT,
        JC_SCAN,
        JC_LOOP,
        JC_DONE
    } jcond_t;

    typedef enum logic [1:0] {
        WK_NONE,
        WK_DOWN,
        WK_UP,
        WK_SHIFT
    } walk_t;

    typedef enum logic [1:0] {
        MD_NONE,
        MD_CMP,
        MD_ACC,
        MD_SHIFT
    } mode_t;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INC,
        CO_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_FOUND,
        RS_SIZE,
        RS_ACC
    } rsrc_t;

    typedef struct packed {
        jcond_t  jcond;
        step_t   target;
        step_t   nxt;
        walk_t   walk;
        logic    run;
        mode_t   mode;
        cnt_op_t cnt_op;
        logic    push_wr;
        logic    load;
        logic    done;
        status_t status;
        rsrc_t   rsrc;
    } ctrl_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic             busy;
        logic             match;
        logic             hit;
        logic [CNT_W-1:0] size;
        logic [CNT_W-1:0] acc;
    } dp_stat_t;

    function automatic step_t op_entry(logic [2:0] op);
        step_t s;
        case (op)
            OP_PUSH:   s = S_PUSH;
            OP_POP:    s = S_POP;
            OP_REMOVE: s = S_REM;
            OP_RADIUS: s = S_RAD_INIT;
            OP_MEMBER: s = S_MEM_INIT;
            OP_SIZE:   s = S_SIZE;
            default:   s = S_NOP;
        endcase
        return s;
    endfunction

    // step program, one control word per step
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w = '0;
        w.jcond  = JC_NONE;
        w.target = S_IDLE;
        w.nxt    = S_IDLE;
        w.walk   = WK_NONE;
        w.mode   = MD_NONE;
        w.cnt_op = CO_HOLD;
        w.status = ST_OK;
        w.rsrc   = RS_ZERO;
        case (s)
            S_IDLE:
            begin
                w.jcond = JC_DISPATCH;
                w.load  = 1'b1;
            end
            S_PUSH:
            begin
                w.jcond  = JC_FULL;
                w.target = S_R_FULL;
                w.nxt    = S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                w.jcond   = JC_DONE;
                w.push_wr = 1'b1;
                w.cnt_op  = CO_INC;
                w.done    = 1'b1;
            end
            S_POP:
            begin
                w.jcond  = JC_EMPTY;
                w.target = S_R_EMPTY;
                w.nxt    = S_POP_DEC;
            end
            S_POP_DEC:
            begin
                w.jcond  = JC_DONE;
                w.cnt_op = CO_DEC;
                w.done   = 1'b1;
            end
            S_REM:
            begin
                w.jcond  = JC_EMPTY;
                w.target = S_R_EMPTY;
                w.nxt    = S_REM_INIT;
            end
            S_REM_INIT:
            begin
                w.walk = WK_DOWN;
                w.nxt  = S_REM_SCAN;
            end
            S_REM_SCAN:
            begin
                w.jcond  = JC_SCAN;
                w.run    = 1'b1;
                w.mode   = MD_CMP;
                w.target = S_REM_SCAN;
                w.nxt    = S_REM_CHK;
            end
            S_REM_CHK:
            begin
                w.jcond  = JC_HIT;
                w.target = S_REM_SHINIT;
                w.nxt    = S_R_NOMATCH;
            end
            S_REM_SHINIT:
            begin
                w.walk = WK_SHIFT;
                w.nxt  = S_REM_SHIFT;
            end
            S_REM_SHIFT:
            begin
                w.jcond  = JC_LOOP;
                w.run    = 1'b1;
                w.mode   = MD_SHIFT;
                w.target = S_REM_SHIFT;
                w.nxt    = S_REM_DEC;
            end
            S_REM_DEC:
            begin
                w.jcond  = JC_DONE;
                w.cnt_op = CO_DEC;
                w.done   = 1'b1;
            end
            S_RAD_INIT:
            begin
                w.walk = WK_UP;
                w.nxt  = S_RAD_SCAN;
            end
            S_RAD_SCAN:
            begin
                w.jcond  = JC_LOOP;
                w.run    = 1'b1;
                w.mode   = MD_ACC;
                w.target = S_RAD_SCAN;
                w.nxt    = S_RAD_DONE;
            end
            S_RAD_DONE:
            begin
                w.jcond = JC_DONE;
                w.done  = 1'b1;
                w.rsrc  = RS_ACC;
            end
            S_MEM_INIT:
            begin
                w.walk = WK_DOWN;
                w.nxt  = S_MEM_SCAN;
            end
            S_MEM_SCAN:
            begin
                w.jcond  = JC_SCAN;
                w.run    = 1'b1;
                w.mode   = MD_CMP;
                w.target = S_MEM_SCAN;
                w.nxt    = S_MEM_DONE;
            end
            S_MEM_DONE:
            begin
                w.jcond = JC_DONE;
                w.done  = 1'b1;
                w.rsrc  = RS_FOUND;
            end
            S_SIZE:
            begin
                w.jcond = JC_DONE;
                w.done  = 1'b1;
                w.rsrc  = RS_SIZE;
            end
            S_NOP:
            begin
                w.jcond = JC_DONE;
                w.done  = 1'b1;
            end
            S_R_FULL:
            begin
                w.jcond  = JC_DONE;
                w.done   = 1'b1;
                w.status = ST_FULL;
            end
            S_R_EMPTY:
            begin
                w.jcond  = JC_DONE;
                w.done   = 1'b1;
                w.status = ST_EMPTY;
            end
            S_R_NOMATCH:
            begin
                w.jcond  = JC_DONE;
                w.done   = 1'b1;
                w.status = ST_NOMATCH;
            end
            default:
            begin
                w.jcond = JC_NONE;
            end
        endcase
        return w;
    endfunction

endpackage

[src/pst_seq.sv]
// ----------------------------------------------------------------------------
// pst_seq: microcode sequencer
// step register, program lookup and conditional jumps
// ----------------------------------------------------------------------------
module pst_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic [2:0]         op,
    input  pst_pkg::dp_stat_t  stat,
    input  logic               res_free,
    output logic               cmd_stall,
    output pst_pkg::ctrl_t     ctrl
);

    pst_pkg::step_t step_reg;
    pst_pkg::step_t step_next;
    pst_pkg::ctrl_t rom;
    logic           hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pst_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        rom  = pst_pkg::ucode(step_reg);
        hold = (rom.jcond == pst_pkg::JC_DONE) && !res_free;

        case (rom.jcond)
            pst_pkg::JC_NONE:     step_next = rom.nxt;
            pst_pkg::JC_DISPATCH: step_next = cmd_valid ? pst_pkg::op_entry(op) : step_reg;
            pst_pkg::JC_FULL:     step_next = stat.full ? rom.target : rom.nxt;
            pst_pkg::JC_EMPTY:    step_next = stat.empty ? rom.target : rom.nxt;
            pst_pkg::JC_HIT:      step_next = stat.hit ? rom.target : rom.nxt;
            pst_pkg::JC_SCAN:     step_next = (stat.busy && !stat.match) ? rom.target : rom.nxt;
            pst_pkg::JC_LOOP:     step_next = stat.busy ? rom.target : rom.nxt;
            pst_pkg::JC_DONE:     step_next = hold ? step_reg : rom.nxt;
            default:              step_next = pst_pkg::S_IDLE;
        endcase

        // side effects of a result step fire once, when the result slot frees
        ctrl      = rom;
        ctrl.load = rom.load && cmd_valid;
        if (hold)
        begin
            ctrl.cnt_op  = pst_pkg::CO_HOLD;
            ctrl.push_wr = 1'b0;
            ctrl.done    = 1'b0;
        end
        cmd_stall = (step_reg != pst_pkg::S_IDLE);
    end

endmodule

[src/pst_datapath.sv]
// ----------------------------------------------------------------------------
// pst_datapath: point store and walk datapath
// coordinate memories, entry count, walker, compare and radius pipeline
// ----------------------------------------------------------------------------
module pst_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pst_pkg::ctrl_t                       ctrl,
    input  logic signed [15:0]                   x_coord,
    input  logic signed [15:0]                   y_coord,
    input  logic [pst_pkg::RADIUS_W-1:0]         radius,
    output pst_pkg::dp_stat_t                    stat
);

    localparam int CW = pst_pkg::COORD_WIDTH;
    localparam int AW = pst_pkg::ADDR_W;
    localparam int NW = pst_pkg::CNT_W;
    localparam int QW = pst_pkg::SQ_W;
    localparam int RW = pst_pkg::RR_W;
    localparam int MW = pst_pkg::CMP_W;

    logic signed [CW-1:0] mem_x [pst_pkg::DEPTH];
    logic signed [CW-1:0] mem_y [pst_pkg::DEPTH];

    logic [NW-1:0]        cnt_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic [RW-1:0]        rr_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        idx_next;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        rem_next;
    logic                 up_reg;
    logic                 up_next;
    logic                 b_vld_reg;
    logic [AW-1:0]        b_idx_reg;
    logic signed [CW-1:0] rdx_reg;
    logic signed [CW-1:0] rdy_reg;
    logic                 c_vld_reg;
    logic [QW-1:0]        x2_reg;
    logic [QW-1:0]        y2_reg;
    logic                 hit_reg;
    logic [AW-1:0]        hit_idx_reg;
    logic [NW-1:0]        acc_reg;

    logic                 issue;
    logic                 eq;
    logic                 inside_r;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [CW-1:0] wr_x;
    logic signed [CW-1:0] wr_y;
    logic signed [QW-1:0] rdx_ext;
    logic signed [QW-1:0] rdy_ext;
    logic [RW-1:0]        rad_ext;

    assign issue    = ctrl.run && (rem_reg != '0);
    assign eq       = (rdx_reg == x_reg) && (rdy_reg == y_reg);
    assign rdx_ext  = QW'(rdx_reg);
    assign rdy_ext  = QW'(rdy_reg);
    assign rad_ext  = RW'(radius);
    assign inside_r = (MW'(x2_reg) + MW'(y2_reg)) <= MW'(rr_reg);

    // walker set-up and stepping
    always_comb
    begin
        idx_next = idx_reg;
        rem_next = rem_reg;
        up_next  = up_reg;
        case (ctrl.walk)
            pst_pkg::WK_DOWN:
            begin
                idx_next = AW'(cnt_reg - 1'b1);
                rem_next = cnt_reg;
                up_next  = 1'b0;
            end
            pst_pkg::WK_UP:
            begin
                idx_next = '0;
                rem_next = cnt_reg;
                up_next  = 1'b1;
            end
            pst_pkg::WK_SHIFT:
            begin
                idx_next = hit_idx_reg + 1'b1;
                rem_next = cnt_reg - NW'(hit_idx_reg) - 1'b1;
                up_next  = 1'b1;
            end
            default:
            begin
                if (issue)
                begin
                    idx_next = up_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
            end
        endcase
    end

    // one write port: push at the top or close the gap one slot down
    always_comb
    begin
        wr_en   = ctrl.push_wr || ((ctrl.mode == pst_pkg::MD_SHIFT) && b_vld_reg);
        wr_addr = ctrl.push_wr ? AW'(cnt_reg) : b_idx_reg - 1'b1;
        wr_x    = ctrl.push_wr ? x_reg : rdx_reg;
        wr_y    = ctrl.push_wr ? y_reg : rdy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        if (issue)
        begin
            rdx_reg <= mem_x[idx_reg];
            rdy_reg <= mem_y[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg  <= CW'(x_coord);
            y_reg  <= CW'(y_coord);
            rr_reg <= rad_ext * rad_ext;
        end
        b_idx_reg <= idx_reg;
        x2_reg    <= QW'(rdx_ext * rdx_ext);
        y2_reg    <= QW'(rdy_ext * rdy_ext);
        if (ctrl.mode == pst_pkg::MD_CMP && b_vld_reg && eq && !hit_reg)
        begin
            hit_idx_reg <= b_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            rem_reg   <= '0;
            up_reg    <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            hit_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            up_reg    <= up_next;
            b_vld_reg <= issue;
            c_vld_reg <= b_vld_reg;
            case (ctrl.cnt_op)
                pst_pkg::CO_INC: cnt_reg <= cnt_reg + 1'b1;
                pst_pkg::CO_DEC: cnt_reg <= cnt_reg - 1'b1;
                default:         cnt_reg <= cnt_reg;
            endcase
            if (ctrl.walk == pst_pkg::WK_DOWN)
            begin
                hit_reg <= 1'b0;
            end
            else if (ctrl.mode == pst_pkg::MD_CMP && b_vld_reg && eq)
            begin
                hit_reg <= 1'b1;
            end
            if (ctrl.walk == pst_pkg::WK_UP)
            begin
                acc_reg <= '0;
            end
            else if (ctrl.mode == pst_pkg::MD_ACC && c_vld_reg && inside_r)
            begin
                acc_reg <= acc_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.empty = (cnt_reg == '0);
        stat.full  = (cnt_reg == NW'(pst_pkg::DEPTH));
        stat.busy  = (rem_reg != '0) || b_vld_reg || c_vld_reg;
        stat.match = b_vld_reg && eq;
        stat.hit   = hit_reg;
        stat.size  = cnt_reg;
        stat.acc   = acc_reg;
    end

endmodule

[src/point_stack_table_core.sv]
// ----------------------------------------------------------------------------
// point_stack_table_core: each command walks the step program to a registered result beat
// radius count and membership scan the stored points, remove scans then shifts the rest down
// one beat at a time: the next command is taken on the edge its result can leave
// reset: entry count zero, point memory undefined until written, no clear pass
// ----------------------------------------------------------------------------
module point_stack_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [2:0]                    op,
    input  logic signed [15:0]            x_coord,
    input  logic signed [15:0]            y_coord,
    input  logic [pst_pkg::RADIUS_W-1:0]  radius,
    // result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [pst_pkg::COUNT_W-1:0]   count
);

    pst_pkg::ctrl_t    ctrl;
    pst_pkg::dp_stat_t stat;

    // result slot: the sequencer may finish the next beat once this drains
    logic                          res_valid_reg;
    pst_pkg::status_t              status_reg;
    logic                          found_reg;
    logic [pst_pkg::COUNT_W-1:0]   count_reg;
    logic                          res_free;
    logic                          res_load;
    logic                          found_val;
    logic [pst_pkg::COUNT_W-1:0]   count_val;

    assign res_free = !res_valid_reg || !res_stall;
    assign res_load = ctrl.done;

    // sequencer: walks the step program, jumps on datapath flags
    pst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .op        (op),
        .stat      (stat),
        .res_free  (res_free),
        .cmd_stall (cmd_stall),
        .ctrl      (ctrl)
    );

    // datapath: point memories, count, walker, compare and radius pipe
    pst_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .radius  (radius),
        .stat    (stat)
    );

    // pick the result fields named by the control word
    always_comb
    begin
        found_val = 1'b0;
        count_val = '0;
        case (ctrl.rsrc)
            pst_pkg::RS_FOUND: found_val = stat.hit;
            pst_pkg::RS_SIZE:  count_val = pst_pkg::COUNT_W'(stat.size);
            pst_pkg::RS_ACC:   count_val = pst_pkg::COUNT_W'(stat.acc);
            default:           found_val = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // payload of the result beat, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg <= ctrl.status;
            found_reg  <= found_val;
            count_reg  <= count_val;
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_reg;

    // an accepted command always takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("sequencer stayed idle after accepting a command");

    // store full reported only when the count is at depth
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && ctrl.status == pst_pkg::ST_FULL) |-> stat.full)
        else $error("store full status with room left");

    // store empty reported only when no point is stored
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && ctrl.status == pst_pkg::ST_EMPTY) |-> stat.empty)
        else $error("store empty status with points stored");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |-> !res_load)
        else $error("result slot overwritten while stalled");

endmodule
